FILE: hw/rtl/lcwmf_pkg.sv
// Shared types, constants and state encodings for the load-cell weight median filter.
package lcwmf_pkg;

  localparam int SAMPLE_W        = 24;
  localparam int WEIGHT_W        = 16;
  localparam int TARE_W          = 16;
  localparam int CAL_W           = 17;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 17;
  localparam int GROUP_LEN_DEF   = 5;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CAL_W-1:0] CAL_COEF_RESET = 17'd47785;

  // floor(x / 100) = (x * RECIP100) >> SHIFT100 for any 24-bit x
  localparam int                RECIP100_W = 25;
  localparam logic [24:0]       RECIP100   = 25'd21474837;
  localparam int                SHIFT100   = 31;

  // floor(y / 3125) = (y * RECIP3125) >> SHIFT3125 for any 28-bit y; 100000 = 32 * 3125
  localparam int                RECIP3125_W = 29;
  localparam logic [28:0]       RECIP3125   = 29'd351843721;
  localparam int                SHIFT3125   = 40;
  localparam int                POW2_SHIFT  = 5;

  localparam logic [CFG_IDX_W-1:0] REG_TARE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_COEF = 1'd1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] gate_sample;
    logic signed [SAMPLE_W-1:0] measure_sample;
  } in_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight_out;
    logic                group_done;
  } out_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SCALE,
    F_DIFF,
    F_MUL,
    F_RECIP,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SORT,
    B_WRITE
  } back_state_t;

endpackage

FILE: hw/rtl/lcwmf_queue.sv
// Small FIFO of computed weights between the front and back sections.
module lcwmf_queue import lcwmf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                full,
  input  logic [WEIGHT_W-1:0] push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output logic [WEIGHT_W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WEIGHT_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/lcwmf_front.sv
// Front section: takes requests, holds configuration, scales codes and computes the weight.
module lcwmf_front import lcwmf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  in_t                   sample,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  push_valid,
  input  logic                  queue_full,
  output logic [WEIGHT_W-1:0]   push_data
);

  localparam int GPROD_W = SAMPLE_W + RECIP100_W;
  localparam int DPROD_W = TARE_W + CAL_W;
  localparam int Y_W     = DPROD_W - POW2_SHIFT;
  localparam int QPROD_W = Y_W + RECIP3125_W;
  localparam int Q_W     = QPROD_W - SHIFT3125;

  front_state_t state, state_next;

  logic [TARE_W-1:0]   tare;
  logic [CAL_W-1:0]    cal_coef;
  logic [SAMPLE_W-1:0] gate_ob;
  logic [SAMPLE_W-1:0] meas_ob;
  logic [TARE_W-1:0]   gate_scaled;
  logic [TARE_W-1:0]   meas_scaled;
  logic                pass;
  logic [TARE_W-1:0]   diff;
  logic [DPROD_W-1:0]  dprod;
  logic [Q_W-1:0]      quot;
  logic [GPROD_W-1:0]  gprod;
  logic [GPROD_W-1:0]  mprod;
  logic [QPROD_W-1:0]  qprod;

  assign cfg_ready    = 1'b1;
  assign sample_stall = (state != F_IDLE);

  assign gprod = GPROD_W'(gate_ob) * GPROD_W'(RECIP100);
  assign mprod = GPROD_W'(meas_ob) * GPROD_W'(RECIP100);
  assign qprod = QPROD_W'(dprod[DPROD_W-1:POW2_SHIFT]) * QPROD_W'(RECIP3125);

  assign push_data = (quot > Q_W'({WEIGHT_W{1'b1}})) ? {WEIGHT_W{1'b1}} : quot[WEIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    push_valid = 1'b0;
    unique case (state)
      F_IDLE:  if (sample_valid) state_next = F_SCALE;
      F_SCALE: state_next = F_DIFF;
      F_DIFF:  state_next = F_MUL;
      F_MUL:   state_next = F_RECIP;
      F_RECIP: state_next = F_PUSH;
      F_PUSH: begin
        push_valid = 1'b1;
        if (!queue_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tare     <= '0;
      cal_coef <= CAL_COEF_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TARE:     tare     <= cfg_data[TARE_W-1:0];
        REG_CAL_COEF: cal_coef <= cfg_data[CAL_W-1:0];
        default:      ;
      endcase
    end
  end

  // offset binary, /100, /100000 via reciprocal multiplies
  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        gate_ob <= {~sample.gate_sample[SAMPLE_W-1], sample.gate_sample[SAMPLE_W-2:0]};
        meas_ob <= {~sample.measure_sample[SAMPLE_W-1], sample.measure_sample[SAMPLE_W-2:0]};
      end
      F_SCALE: begin
        gate_scaled <= gprod[SHIFT100 +: TARE_W];
        meas_scaled <= mprod[SHIFT100 +: TARE_W];
      end
      F_DIFF: begin
        pass <= (gate_scaled > tare) && (meas_scaled > tare);
        diff <= meas_scaled - tare;
      end
      F_MUL:   dprod <= pass ? DPROD_W'(diff) * DPROD_W'(cal_coef) : '0;
      F_RECIP: quot  <= qprod[QPROD_W-1:SHIFT3125];
      F_PUSH:  ;
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/lcwmf_back.sv
// Back section: sorted insertion into the group and the result register.
module lcwmf_back import lcwmf_pkg::*; #(
  parameter int GROUP_LEN = GROUP_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  logic [WEIGHT_W-1:0] pop_data,
  output logic                weight_valid,
  input  logic                weight_stall,
  output out_t                weight
);

  localparam int IDX_W  = $clog2(GROUP_LEN);
  localparam int FILL_W = $clog2(GROUP_LEN + 1);
  localparam int MID    = (GROUP_LEN - 1) / 2;
  localparam logic [FILL_W-1:0] LAST_FILL = FILL_W'(GROUP_LEN - 1);

  back_state_t state, state_next;

  logic [WEIGHT_W-1:0] store [GROUP_LEN];
  logic [WEIGHT_W-1:0] w_cur;
  logic [IDX_W-1:0]    idx;
  logic [FILL_W-1:0]   fill;
  logic                out_free;
  logic                write_fire;
  logic                done;
  logic                sort_end;

  assign out_free   = !weight_valid || !weight_stall;
  assign done       = (fill == LAST_FILL);
  assign sort_end   = (FILL_W'(idx) == fill);
  assign write_fire = (state == B_WRITE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    unique case (state)
      B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) state_next = B_SORT;
      end
      B_SORT:  if (sort_end) state_next = B_WRITE;
      B_WRITE: if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // one compare-and-swap per cycle; w_cur ends as the running maximum
  always_ff @(posedge clk) begin
    if (state == B_IDLE && pop_valid) begin
      w_cur <= pop_data;
      idx   <= '0;
    end else if (state == B_SORT && !sort_end) begin
      if (store[idx] > w_cur) begin
        store[idx] <= w_cur;
        w_cur      <= store[idx];
      end
      idx <= idx + 1'b1;
    end else if (write_fire) begin
      store[fill[IDX_W-1:0]] <= w_cur;
      weight.weight_out      <= done ? store[MID] : w_cur;
      weight.group_done      <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      weight_valid <= 1'b0;
    end else begin
      if (write_fire) begin
        fill         <= done ? '0 : fill + 1'b1;
        weight_valid <= 1'b1;
      end else if (!weight_stall) begin
        weight_valid <= 1'b0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill < FILL_W'(GROUP_LEN))
    else $error("group fill reached group length");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    state == B_SORT |-> FILL_W'(idx) <= fill)
    else $error("sort index ran past fill");

  a_done_flag: assert property (@(posedge clk) disable iff (rst)
    write_fire |=> weight_valid && (weight.group_done == ($past(fill) == LAST_FILL)))
    else $error("group_done does not match group fill");

  a_group_restart: assert property (@(posedge clk) disable iff (rst)
    write_fire && done |=> fill == '0)
    else $error("group did not restart after median");

endmodule

FILE: hw/rtl/load_cell_weight_median_filter.sv
// Load-cell weight median filter: top level joining front, queue and back sections.
// Usage:
//   sample channel (sample_valid / sample_stall / sample) carries a gate and a measure
//   code. A request is taken when sample_valid is high and sample_stall is low.
//   weight channel (weight_valid / weight_stall / weight) gives one result per request:
//   the largest weight of the current group, or the median once the group of
//   GROUP_LEN is complete (group_done set), after which the group restarts.
//   cfg channel writes tare (index 0) and cal_coef (index 1); cfg_ready is always high.
//   Write configuration only while no request is in flight.
// Flow:
//   The front sequencer steps through capture, scale, gate/diff, calibration
//   multiply, reciprocal divide and push, and takes the next request only once
//   the queue has taken the push. The back inserts each result into the group with
//   one compare per cycle against each entry already there, then writes the output.
//   A two-entry queue separates the sections; a stalled result is held in the
//   output register while the front keeps computing until the queue fills.
// Reset: rst clears the group fill, the queue and both sequencers, sets tare to 0
//   and cal_coef to 47785.
module load_cell_weight_median_filter import lcwmf_pkg::*; #(
  parameter int GROUP_LEN   = GROUP_LEN_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  in_t                   sample,
  output logic                  weight_valid,
  input  logic                  weight_stall,
  output out_t                  weight,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                push_valid;
  logic                queue_full;
  logic [WEIGHT_W-1:0] push_data;
  logic                pop_valid;
  logic                pop_ready;
  logic [WEIGHT_W-1:0] pop_data;

  lcwmf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push_valid   (push_valid),
    .queue_full   (queue_full),
    .push_data    (push_data)
  );

  lcwmf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .full       (queue_full),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lcwmf_back #(
    .GROUP_LEN (GROUP_LEN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .weight_valid (weight_valid),
    .weight_stall (weight_stall),
    .weight       (weight)
  );

endmodule

FILE: tb/sv/load_cell_weight_median_filter_tb.sv
// Self-checking testbench for the load-cell weight median filter.
`timescale 1ns / 1ps

module load_cell_weight_median_filter_tb;
  import lcwmf_pkg::*;

  localparam logic [SAMPLE_W-1:0] SIGN_BIT   = 24'h800000;
  localparam int                  SCALED_MAX = 167772;
  localparam int                  WRAP_SPAN  = 65536;
  localparam int                  WEIGHT_TOP = 65535;
  localparam int                  MEDIAN_IDX = (GROUP_LEN_DEF - 1) / 2;
  localparam int                  DRAIN      = 24;
  localparam int                  CYCLE_LIMIT = 400000;

  class weight_tracker;
    logic [TARE_W-1:0]   tare;
    logic [CAL_W-1:0]    cal_coef;
    logic [WEIGHT_W-1:0] group_sorted [GROUP_LEN_DEF];
    int unsigned         fill;
    out_t                weights_due [$];
    int unsigned         mismatches;

    function new();
      tare = '0;
      cal_coef = CAL_COEF_RESET;
      fill = 0;
      mismatches = 0;
      foreach (group_sorted[i]) group_sorted[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_TARE) tare = val[TARE_W-1:0];
      else if (idx == REG_CAL_COEF) cal_coef = val[CAL_W-1:0];
    endfunction

    function logic [WEIGHT_W-1:0] scaled(logic [SAMPLE_W-1:0] code);
      logic [SAMPLE_W-1:0] q;
      q = (code ^ SIGN_BIT) / 24'd100;
      return q[WEIGHT_W-1:0];
    endfunction

    function logic [WEIGHT_W-1:0] weight_of(in_t s);
      logic [WEIGHT_W-1:0] g;
      logic [WEIGHT_W-1:0] m;
      logic [33:0]         diff;
      logic [33:0]         prod;
      g = scaled(s.gate_sample);
      if (g <= tare) return '0;
      m = scaled(s.measure_sample);
      if (m <= tare) return '0;
      diff = {18'd0, m - tare};
      prod = (diff * {17'd0, cal_coef}) / 34'd100000;
      if (prod > WEIGHT_TOP) return 16'hFFFF;
      return prod[WEIGHT_W-1:0];
    endfunction

    // insertion into the ascending group, one result per request
    function void take_sample(in_t s);
      logic [WEIGHT_W-1:0] w;
      logic [WEIGHT_W-1:0] t;
      out_t                res;
      w = weight_of(s);
      res.group_done = 1'b0;
      if (fill >= GROUP_LEN_DEF) fill = 0;
      for (int i = 0; i < fill; i++) begin
        if (group_sorted[i] > w) begin
          t = group_sorted[i];
          group_sorted[i] = w;
          w = t;
        end
      end
      group_sorted[fill] = w;
      fill++;
      if (fill >= GROUP_LEN_DEF) begin
        w = group_sorted[MEDIAN_IDX];
        fill = 0;
        res.group_done = 1'b1;
      end
      res.weight_out = w;
      weights_due.push_back(res);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_weight(out_t got);
      out_t want;
      if (weights_due.size() == 0) begin
        report($sformatf("unexpected weight %0d done %0b", got.weight_out, got.group_done));
      end else begin
        want = weights_due.pop_front();
        if (got.weight_out !== want.weight_out)
          report($sformatf("weight_out %0d, want %0d", got.weight_out, want.weight_out));
        if (got.group_done !== want.group_done)
          report($sformatf("group_done %0b, want %0b", got.group_done, want.group_done));
      end
    endtask

    function int outstanding();
      return weights_due.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  in_t                   sample = '0;
  logic                  weight_valid;
  logic                  weight_stall = 1'b0;
  out_t                  weight;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  weight_tracker sb;
  int            send_idle_pct = 0;
  int            stall_pct = 0;
  int unsigned   cycles = 0;

  load_cell_weight_median_filter dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .weight_valid (weight_valid),
    .weight_stall (weight_stall),
    .weight       (weight),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && weight_valid && !weight_stall) sb.check_weight(weight);
    weight_stall <= ($urandom_range(99) < stall_pct);
  end

  // code whose scaled 16-bit value is t, with a random wrap and remainder
  function automatic logic [SAMPLE_W-1:0] code_for(int t);
    int                  k;
    int                  s;
    int                  ob;
    logic [SAMPLE_W-1:0] v;
    k = $urandom_range((SCALED_MAX - t) / WRAP_SPAN, 0);
    s = t + k * WRAP_SPAN;
    ob = s * 100 + $urandom_range((s == SCALED_MAX) ? 15 : 99, 0);
    v = ob[SAMPLE_W-1:0];
    return v ^ SIGN_BIT;
  endfunction

  function automatic int clamp16(int v);
    if (v < 0) return 0;
    if (v > WEIGHT_TOP) return WEIGHT_TOP;
    return v;
  endfunction

  function automatic in_t pair(int gt, int mt);
    in_t s;
    s.gate_sample = code_for(clamp16(gt));
    s.measure_sample = code_for(clamp16(mt));
    return s;
  endfunction

  function automatic in_t random_item(int t);
    in_t s;
    int  gt;
    int  mt;
    int  pick;
    pick = $urandom_range(99);
    if (pick < 25) begin
      s.gate_sample = SAMPLE_W'($urandom);
      s.measure_sample = SAMPLE_W'($urandom);
      return s;
    end
    if ($urandom_range(9) < 8) gt = t + $urandom_range(20000, 1);
    else gt = t - $urandom_range(2, 0);
    pick = $urandom_range(99);
    if (pick < 15) mt = t - $urandom_range(3, 0);
    else if (pick < 55) mt = t + $urandom_range(2000, 1);
    else mt = t + $urandom_range(WEIGHT_TOP, 1);
    return pair(gt, mt);
  endfunction

  task automatic send_item(in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (sample_stall);
    sb.take_sample(s);
  endtask

  task automatic settle();
    sample_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val[CFG_DATA_W-1:0]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(int t, int c, int n, int s_idle, int r_stall);
    settle();
    write_reg(REG_TARE, t);
    write_reg(REG_CAL_COEF, c);
    send_idle_pct = s_idle;
    stall_pct = r_stall;
    repeat (n) send_item(random_item(t));
  endtask

  initial begin
    in_t s;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: tare 0, default coefficient
    s.gate_sample = 24'h800000; s.measure_sample = 24'h7FFFFF; send_item(s);
    s.gate_sample = 24'h7FFFFF; s.measure_sample = 24'h800000; send_item(s);
    s.gate_sample = 24'h7FFFFF; s.measure_sample = 24'h7FFFFF; send_item(s);
    s.gate_sample = 24'h000000; s.measure_sample = 24'hFFFFFF; send_item(s);
    send_item(pair(WEIGHT_TOP, WEIGHT_TOP));
    send_item(pair(1, 1));
    send_item(pair(3, 3));
    send_item(pair(WEIGHT_TOP, 40000));
    send_item(pair(2, WEIGHT_TOP));
    send_item(pair(WEIGHT_TOP, 0));

    // gate edges and saturation at the top coefficient
    settle();
    write_reg(REG_TARE, 100);
    write_reg(REG_CAL_COEF, 131071);
    send_item(pair(100, 5000));
    send_item(pair(99, 5000));
    send_item(pair(101, 100));
    send_item(pair(101, 101));
    send_item(pair(WEIGHT_TOP, WEIGHT_TOP));
    send_item(pair(200, 50100));
    send_item(pair(200, 50099));
    send_item(pair(300, 99));

    run_phase(1000, 47785, 100, 0, 0);
    run_phase(30000, 131071, 100, 65, 0);
    run_phase(0, 131071, 100, 0, 65);
    run_phase(65535, 0, 50, 14, 14);
    run_phase(12345, 99999, 100, 14, 14);
    run_phase(500, 1, 50, 0, 0);
    run_phase(40000, 60000, 100, 65, 65);

    settle();
    if (sb.mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/lcwmf_pkg.sv
hw/rtl/lcwmf_queue.sv
hw/rtl/lcwmf_front.sv
hw/rtl/lcwmf_back.sv
hw/rtl/load_cell_weight_median_filter.sv
tb/sv/load_cell_weight_median_filter_tb.sv
